[hdl/cppm_pkg.sv]
`timescale 1ns / 1ps

package cppm_pkg;

    localparam int EdgeTimeW  = 16;
    localparam int ChannelW   = 4;
    localparam int PulseW     = 16;
    localparam int SyncGapW   = 16;
    localparam int SlotW      = 4;

    typedef logic [SlotW-1:0]    t_slot;
    typedef logic [ChannelW-1:0] t_channel;

    localparam t_slot SLOT_FRAME_START = 4'd0;
    localparam t_slot SLOT_FIRST_CHAN  = 4'd1;
    localparam t_slot SLOT_LAST_PRIM   = 4'd4;
    localparam t_slot SLOT_LAST_CHAN   = 4'd8;
    localparam t_slot SLOT_IDLE        = 4'd9;

    typedef struct packed {
        t_channel            channel;
        logic [PulseW-1:0]   pulse_width;
        logic                primary_update;
    } t_result;

    typedef struct packed {
        logic    emit;
        t_slot   slot_next;
        t_result result;
    } t_decode;

    // receiver order: first four slots carry channels 3, 1, 2, 4
    function automatic t_channel chan_of_slot(input t_slot slot);
        t_channel chan;
        case (slot)
            4'd1: chan = 4'd3;
            4'd2: chan = 4'd1;
            4'd3: chan = 4'd2;
            4'd4: chan = 4'd4;
            4'd5: chan = 4'd5;
            4'd6: chan = 4'd6;
            4'd7: chan = 4'd7;
            4'd8: chan = 4'd8;
            default: chan = 4'd0;
        endcase
        return chan;
    endfunction

endpackage

[hdl/cppm_edge_if.sv]
`timescale 1ns / 1ps

interface cppm_edge_if;
    logic                            valid;
    logic                            ready;
    logic [cppm_pkg::EdgeTimeW-1:0]  edge_time;

    modport source (output valid, output edge_time, input ready);
    modport sink   (input valid, input edge_time, output ready);
endinterface

[hdl/cppm_chan_if.sv]
`timescale 1ns / 1ps

interface cppm_chan_if;
    logic                          valid;
    logic                          ready;
    logic [cppm_pkg::ChannelW-1:0] channel;
    logic [cppm_pkg::PulseW-1:0]   pulse_width;
    logic                          primary_update;

    modport source (output valid, output channel, output pulse_width, output primary_update,
                    input ready);
    modport sink   (input valid, input channel, input pulse_width, input primary_update,
                    output ready);
endinterface

[hdl/cppm_decode.sv]
`timescale 1ns / 1ps

module cppm_decode #(
    parameter int TIMER_BITS = 16
) (
    input  logic [TIMER_BITS-1:0]          i_now,
    input  logic [TIMER_BITS-1:0]          i_last,
    input  logic [cppm_pkg::SyncGapW-1:0]  i_sync_gap,
    input  cppm_pkg::t_slot                i_slot,
    output cppm_pkg::t_decode              o_decode
);

    localparam int CmpW = (TIMER_BITS > cppm_pkg::SyncGapW) ? TIMER_BITS : cppm_pkg::SyncGapW;

    logic [TIMER_BITS-1:0] gap;
    logic                  is_sync;
    cppm_pkg::t_slot       slot;

    assign gap     = i_now - i_last;
    assign is_sync = CmpW'(gap) > CmpW'(i_sync_gap);

    always_comb begin
        if (is_sync) begin
            slot = cppm_pkg::SLOT_FRAME_START;
        end else if (i_slot > cppm_pkg::SLOT_IDLE) begin
            slot = cppm_pkg::SLOT_IDLE;
        end else begin
            slot = i_slot;
        end

        o_decode.emit = (slot >= cppm_pkg::SLOT_FIRST_CHAN) &&
                        (slot <= cppm_pkg::SLOT_LAST_CHAN);
        o_decode.slot_next = (slot < cppm_pkg::SLOT_IDLE) ? slot + 4'd1 : cppm_pkg::SLOT_IDLE;
        o_decode.result.channel        = cppm_pkg::chan_of_slot(slot);
        o_decode.result.pulse_width    = cppm_pkg::PulseW'(gap);
        o_decode.result.primary_update = slot <= cppm_pkg::SLOT_LAST_PRIM;
    end

endmodule

[hdl/cppm_frame_decoder.sv]
`timescale 1ns / 1ps

// Combined PPM decoder for eight channels. Each input item is the timer stamp of one stream
// edge; the gap to the previous edge (modulo 2^TIMER_BITS) above sync_gap opens a new frame,
// and the edges that follow in slots 1-8 each deliver one item with the width of the pulse that ended and
// its receiver channel (slots 1-4 give channels 3, 1, 2, 4, slots 5-8 give 5-8), with
// primary_update set for the first four. Edges past slot 8 and before the first sync
// give nothing. One item is taken every cycle; an edge passes an input register and a
// subtract-and-compare stage into the result register, and the input stalls only while
// both the input register and the result register hold items and the result is not taken.
module cppm_frame_decoder #(
    parameter int TIMER_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cppm_pkg::SyncGapW-1:0] i_cfg_wdata,
    cppm_edge_if.sink                     i_edge,
    cppm_chan_if.source                   o_chan
);

    logic                          r_in_valid;
    logic [TIMER_BITS-1:0]         r_in_time;
    logic [TIMER_BITS-1:0]         r_last;
    cppm_pkg::t_slot               r_slot;
    logic [cppm_pkg::SyncGapW-1:0] r_sync_gap;
    logic                          r_out_valid;
    cppm_pkg::t_result             r_out;

    logic              advance;
    cppm_pkg::t_decode dec;

    assign advance      = !r_out_valid || o_chan.ready;
    assign i_edge.ready = !r_in_valid || advance;

    cppm_decode #(
        .TIMER_BITS (TIMER_BITS)
    ) u_decode (
        .i_now      (r_in_time),
        .i_last     (r_last),
        .i_sync_gap (r_sync_gap),
        .i_slot     (r_slot),
        .o_decode   (dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_last      <= '0;
            r_slot      <= cppm_pkg::SLOT_IDLE;
            r_sync_gap  <= 16'd5000;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_sync_gap <= i_cfg_wdata;
            end
            if (i_edge.ready) begin
                r_in_valid <= i_edge.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid && dec.emit;
                if (r_in_valid) begin
                    r_last <= r_in_time;
                    r_slot <= dec.slot_next;
                end
            end
        end
        if (i_edge.valid && i_edge.ready) begin
            r_in_time <= TIMER_BITS'(i_edge.edge_time);
        end
        if (advance && r_in_valid && dec.emit) begin
            r_out <= dec.result;
        end
    end

    assign o_chan.valid          = r_out_valid;
    assign o_chan.channel        = r_out.channel;
    assign o_chan.pulse_width    = r_out.pulse_width;
    assign o_chan.primary_update = r_out.primary_update;

endmodule
